// ----- hw/rtl/scp_pkg.sv -----
package scp_pkg;

  localparam int unsigned LINE_LEN  = 13;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned MAG_W     = 10;
  localparam int unsigned PCT_LIMIT = 100;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [MAG_W-1:0] mag_t;

  // byte positions of the fixed layout
  localparam pos_t POS_LX_L  = 4'd0;
  localparam pos_t POS_LX_X  = 4'd1;
  localparam pos_t POS_X_SGN = 4'd2;
  localparam pos_t POS_X_D0  = 4'd3;
  localparam pos_t POS_X_D1  = 4'd4;
  localparam pos_t POS_X_D2  = 4'd5;
  localparam pos_t POS_SPACE = 4'd6;
  localparam pos_t POS_LY_L  = 4'd7;
  localparam pos_t POS_LY_Y  = 4'd8;
  localparam pos_t POS_Y_SGN = 4'd9;
  localparam pos_t POS_Y_D0  = 4'd10;
  localparam pos_t POS_Y_D1  = 4'd11;
  localparam pos_t POS_Y_D2  = 4'd12;
  localparam pos_t POS_DONE  = 4'(LINE_LEN);

  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam mag_t MAG_LIMIT = MAG_W'(PCT_LIMIT);

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  // mag * 10 + digit, kept to MAG_W bits
  function automatic mag_t add_digit(input mag_t mag, input logic [7:0] c);
    logic [7:0] d;
    d = is_digit(c) ? (c - CH_ZERO) : 8'd0;
    return MAG_W'((mag << 3) + (mag << 1) + MAG_W'(d));
  endfunction

endpackage

// ----- hw/rtl/scp_if.sv -----
interface scp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       line_end;

  modport source (output valid, output char_byte, output line_end, input ready);
  modport sink   (input valid, input char_byte, input line_end, output ready);
endinterface

interface scp_out_if;
  logic              valid;
  logic              ready;
  logic              ok;
  logic signed [7:0] x_percent;
  logic signed [7:0] y_percent;

  modport source (output valid, output ok, output x_percent, output y_percent,
                  input ready);
  modport sink   (input valid, input ok, input x_percent, input y_percent,
                  output ready);
endinterface

// ----- hw/rtl/stick_command_line_parser_unit.sv -----
// Stick command line parser.
// in_if carries one character per item (char_byte) and line_end on the
// last character of a line. out_if carries one result item per line:
// ok and the two signed percentages x_percent / y_percent (zero if not ok).
// The line must read "LX" sign ddd ' ' "LY" sign ddd in its first 13
// bytes; later bytes are ignored, shorter lines give ok = 0.
// Throughput: one character per cycle while in_if.ready is high; the
// position counter and digit accumulate sit between the input register
// and the state. The result passes the input register, then the result
// register, and is valid once it is in the result register.
// Characters that do not end a line never wait on the output side. When
// the receiver stalls, a pending result holds, one line end may sit in
// the input register, and in_if.ready drops only while that line end
// cannot move into the result register.
// Reset (rst_n low, synchronous) empties both registers and returns the
// line state to the start of a line.
module stick_command_line_parser_unit (
  input  logic      clk,
  input  logic      rst_n,
  scp_in_if.sink    in_if,
  scp_out_if.source out_if
);
  import scp_pkg::*;

  // input register
  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       in_end_r;

  // line state
  pos_t pos_r, pos_nxt;
  logic bad_r, bad_nxt;
  logic xneg_r, xneg_nxt;
  logic yneg_r, yneg_nxt;
  mag_t xmag_r, xmag_nxt;
  mag_t ymag_r, ymag_nxt;

  // result register
  logic              out_valid_r;
  logic              out_ok_r;
  logic signed [7:0] out_x_r;
  logic signed [7:0] out_y_r;

  logic s1_fire;
  logic good;
  logic line_ok;

  assign s1_fire     = in_valid_r && (!in_end_r || !out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
    if (in_if.ready && in_if.valid) begin
      in_char_r <= in_if.char_byte;
      in_end_r  <= in_if.line_end;
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    bad_nxt  = bad_r;
    xneg_nxt = xneg_r;
    yneg_nxt = yneg_r;
    xmag_nxt = xmag_r;
    ymag_nxt = ymag_r;
    good     = 1'b1;
    if (pos_r < POS_DONE) begin
      pos_nxt = pos_r + 4'd1;
      case (pos_r)
        POS_LX_L, POS_LY_L: good = (in_char_r == CH_L);
        POS_LX_X:           good = (in_char_r == CH_X);
        POS_LY_Y:           good = (in_char_r == CH_Y);
        POS_SPACE:          good = (in_char_r == CH_SPACE);
        POS_X_SGN: begin
          good     = is_sign(in_char_r);
          xneg_nxt = (in_char_r == CH_MINUS);
        end
        POS_Y_SGN: begin
          good     = is_sign(in_char_r);
          yneg_nxt = (in_char_r == CH_MINUS);
        end
        POS_X_D0, POS_X_D1, POS_X_D2: begin
          good     = is_digit(in_char_r);
          xmag_nxt = add_digit(xmag_r, in_char_r);
        end
        POS_Y_D0, POS_Y_D1, POS_Y_D2: begin
          good     = is_digit(in_char_r);
          ymag_nxt = add_digit(ymag_r, in_char_r);
        end
        default: good = 1'b1;
      endcase
      if (!good) begin
        bad_nxt = 1'b1;
      end
    end
    line_ok = (pos_nxt == POS_DONE) && !bad_nxt &&
              (xmag_nxt <= MAG_LIMIT) && (ymag_nxt <= MAG_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      bad_r  <= 1'b0;
      xneg_r <= 1'b0;
      yneg_r <= 1'b0;
      xmag_r <= '0;
      ymag_r <= '0;
    end else if (s1_fire) begin
      if (in_end_r) begin
        pos_r  <= '0;
        bad_r  <= 1'b0;
        xneg_r <= 1'b0;
        yneg_r <= 1'b0;
        xmag_r <= '0;
        ymag_r <= '0;
      end else begin
        pos_r  <= pos_nxt;
        bad_r  <= bad_nxt;
        xneg_r <= xneg_nxt;
        yneg_r <= yneg_nxt;
        xmag_r <= xmag_nxt;
        ymag_r <= ymag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && in_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_fire && in_end_r) begin
      out_ok_r <= line_ok;
      if (line_ok) begin
        out_x_r <= xneg_nxt ? -$signed(xmag_nxt[7:0]) : $signed(xmag_nxt[7:0]);
        out_y_r <= yneg_nxt ? -$signed(ymag_nxt[7:0]) : $signed(ymag_nxt[7:0]);
      end else begin
        out_x_r <= '0;
        out_y_r <= '0;
      end
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.ok        = out_ok_r;
  assign out_if.x_percent = out_x_r;
  assign out_if.y_percent = out_y_r;

endmodule

// ----- hw/rtl/scp_checker.sv -----
module scp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_ok,
  input logic signed [7:0] out_x,
  input logic signed [7:0] out_y
);

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a rejected line always reports zero values
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> (out_x == 8'sd0) && (out_y == 8'sd0))
    else $error("invalid line with nonzero values");

  // an accepted line stays within the percent range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok |->
      (out_x >= -8'sd100) && (out_x <= 8'sd100) &&
      (out_y >= -8'sd100) && (out_y <= 8'sd100))
    else $error("percent out of range");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stick_command_line_parser_unit scp_checker u_scp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_ok    (out_if.ok),
  .out_x     (out_if.x_percent),
  .out_y     (out_if.y_percent)
);
